/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers; they compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define CHK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CHK_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CHK_ALWAYS(label, clk, rst, cond, msg)
`define CHK_IMPLIES(label, clk, rst, ante, cons, msg)
`define CHK_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* src/cnc_home_pkg.sv */
// ----------------------------------------------------------------------------
// cnc_home_pkg
// shared widths, register codes, reset values and result types of the
// limit switch homing sequencer
// ----------------------------------------------------------------------------
package cnc_home_pkg;

   localparam int PULSE_W    = 8;
   localparam int INVERT_W   = 6;
   localparam int AXIS_W     = 3;
   localparam int BASE_W     = 16;
   localparam int LEAVE_W    = 8;
   localparam int SETTLE_W   = 20;
   localparam int PERIOD_W   = BASE_W + 5;   // base delay times 32
   localparam int CSR_DATA_W = 20;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULSE_WIDTH   = 3'd0,
      CSR_OUTPUT_INVERT = 3'd1,
      CSR_LIMIT_INVERT  = 3'd2,
      CSR_BASE_DELAY    = 3'd3,
      CSR_LEAVE_PULSES  = 3'd4,
      CSR_AXES_PRESENT  = 3'd5,
      CSR_Y_BEFORE_X    = 3'd6,
      CSR_SETTLE_TIME   = 3'd7
   } csr_index_type;

   localparam logic [PULSE_W-1:0]  RST_PULSE_WIDTH   = 8'd10;
   localparam logic [INVERT_W-1:0] RST_OUTPUT_INVERT = 6'd0;
   localparam logic [AXIS_W-1:0]   RST_LIMIT_INVERT  = 3'd0;
   localparam logic [BASE_W-1:0]   RST_BASE_DELAY    = 16'd250;
   localparam logic [LEAVE_W-1:0]  RST_LEAVE_PULSES  = 8'd10;
   localparam logic [AXIS_W-1:0]   RST_AXES_PRESENT  = 3'd7;
   localparam logic                RST_Y_BEFORE_X    = 1'b0;
   localparam logic [SETTLE_W-1:0] RST_SETTLE_TIME   = 20'd50000;

   localparam logic [AXIS_W-1:0] AXIS_NONE = 3'b000;
   localparam logic [AXIS_W-1:0] AXIS_X    = 3'b001;
   localparam logic [AXIS_W-1:0] AXIS_Y    = 3'b010;
   localparam logic [AXIS_W-1:0] AXIS_Z    = 3'b100;
   localparam logic [AXIS_W-1:0] AXIS_ALL  = 3'b111;

   // homing order slots: Z first, then the two lateral axes
   localparam logic [1:0] SLOT_Z    = 2'd0;
   localparam logic [1:0] SLOT_A    = 2'd1;
   localparam logic [1:0] SLOT_B    = 2'd2;
   localparam logic [1:0] SLOT_NONE = 2'd3;

   typedef struct packed {
      logic [AXIS_W-1:0] step;
      logic [AXIS_W-1:0] dir;
      logic              enable;
      logic              busy;
      logic              done;
      logic              pos_clear;
   } rsp_payload_type;

   function automatic logic [AXIS_W-1:0] slot_mask(logic [1:0] slot, logic y_first);
      logic [AXIS_W-1:0] m;
      case (slot)
         SLOT_Z:  m = AXIS_Z;
         SLOT_A:  m = y_first ? AXIS_Y : AXIS_X;
         SLOT_B:  m = y_first ? AXIS_X : AXIS_Y;
         default: m = AXIS_NONE;
      endcase
      return m;
   endfunction

endpackage

/* src/cnc_homing_sequencer_core.sv */
// ----------------------------------------------------------------------------
// cnc_homing_sequencer_core
// limit switch homing sequencer driven by a one microsecond tick per request
// ----------------------------------------------------------------------------
// Each request is one timebase tick and yields exactly one response holding
// the step, direction, enable, busy, done and position clear levels after
// that tick. The block takes one request per clock while req_stall is low,
// and each response is registered before it leaves. All phase changes
// whose wait is zero ticks are resolved in the same clock (at most four in a
// row), and the step period shrink (one constant reciprocal multiply) sits in
// that same path. An output register backed by a one-entry skid register
// decouples the sides: req_stall rises only while the skid register is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnc_homing_sequencer_core
   import cnc_home_pkg::*;
#(
   parameter int DELAY_WIDTH = 24
)(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_req,
   input  logic [AXIS_W-1:0]      req_limit_pins,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [AXIS_W-1:0]      rsp_step_pins,
   output logic [AXIS_W-1:0]      rsp_dir_pins,
   output logic                   rsp_motor_enable,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_position_clear,

   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TIMER_W   = (DELAY_WIDTH > SETTLE_W) ? DELAY_WIDTH : SETTLE_W;
   localparam int SAT_W     = (DELAY_WIDTH > PERIOD_W) ? DELAY_WIDTH : PERIOD_W;
   localparam int RED_SHIFT = DELAY_WIDTH + 6;
   localparam int QUOT_W    = DELAY_WIDTH - 5;
   localparam logic [DELAY_WIDTH:0] RECIP50 =
      (DELAY_WIDTH+1)'(((64'd1 << RED_SHIFT) + 64'd49) / 64'd50);
   localparam logic [SAT_W-1:0] DELAY_MAX_EXT =
      SAT_W'((64'd1 << DELAY_WIDTH) - 64'd1);

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_A_SETUP  = 4'd1,
      PH_A_PULSE  = 4'd2,
      PH_A_GAP    = 4'd3,
      PH_A_SETTLE = 4'd4,
      PH_L_SETUP  = 4'd5,
      PH_L_PULSE  = 4'd6,
      PH_L_GAP    = 4'd7,
      PH_L_XHIGH  = 4'd8,
      PH_L_XLOW   = 4'd9,
      PH_L_SETTLE = 4'd10,
      PH_FINAL    = 4'd11
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [1:0]             slot;
      logic [AXIS_W-1:0]      active;
      logic [DELAY_WIDTH-1:0] sp;
      logic [LEAVE_W-1:0]     extra;
      logic                   done;
   } chain_type;

   typedef struct packed {
      logic [PULSE_W-1:0]     pw;
      logic [PULSE_W-1:0]     high_time;
      logic [SETTLE_W-1:0]    settle;
      logic                   pw_zero;
      logic                   settle_zero;
      logic                   base_zero;
      logic [AXIS_W-1:0]      lb_approach;
      logic [AXIS_W-1:0]      lb_leave;
      logic [AXIS_W-1:0]      present;
      logic                   ybx;
      logic [LEAVE_W-1:0]     leave_pulses;
      logic [DELAY_WIDTH-1:0] sp_approach;
      logic [DELAY_WIDTH-1:0] sp_leave;
      logic [DELAY_WIDTH-1:0] sp_reduced;
      logic [DELAY_WIDTH-1:0] sp_xlow;
      logic                   reduce_ok;
   } ctx_type;

   // configuration registers
   logic [PULSE_W-1:0]  pulse_width_ff;
   logic [INVERT_W-1:0] output_invert_ff;
   logic [AXIS_W-1:0]   limit_invert_ff;
   logic [BASE_W-1:0]   base_delay_ff;
   logic [LEAVE_W-1:0]  leave_pulses_ff;
   logic [AXIS_W-1:0]   axes_present_ff;
   logic                y_before_x_ff;
   logic [SETTLE_W-1:0] settle_time_ff;

   // sequencer state
   phase_type              phase_ff, phase_in;
   logic [1:0]             slot_ff, slot_in;
   logic [AXIS_W-1:0]      active_ff, active_in;
   logic [DELAY_WIDTH-1:0] sp_ff, sp_in;
   logic [TIMER_W-1:0]     timer_ff, timer_in;
   logic [LEAVE_W-1:0]     extra_ff, extra_in;

   // output side
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff, skid_data_in;

   logic            req_accept;
   logic            rsp_take;
   rsp_payload_type rsp_new;
   ctx_type         ctx;
   chain_type       chain_end;

   logic [2*DELAY_WIDTH:0]  red_prod;
   logic [QUOT_W-1:0]       red_quot;
   logic [DELAY_WIDTH-1:0]  red_quot50;
   logic                    red_rem_nz;
   logic [PERIOD_W-1:0]     per_approach;
   logic [PERIOD_W-1:0]     per_leave;

   function automatic logic [DELAY_WIDTH-1:0] sat_delay(logic [PERIOD_W-1:0] v);
      logic [SAT_W-1:0] ext;
      ext = SAT_W'(v);
      return (ext > DELAY_MAX_EXT) ? {DELAY_WIDTH{1'b1}} : ext[DELAY_WIDTH-1:0];
   endfunction

   function automatic logic [PERIOD_W-1:0] sub_floor(logic [PERIOD_W-1:0] p,
                                                     logic [PULSE_W-1:0] pw);
      return (p > PERIOD_W'(pw)) ? p - PERIOD_W'(pw) : '0;
   endfunction

   function automatic chain_type do_check(chain_type c, logic [AXIS_W-1:0] lb,
                                          phase_type ph);
      chain_type n;
      n        = c;
      n.active = c.active & lb;
      n.phase  = ph;
      return n;
   endfunction

   // first fitted axis at or after slot 'from', else the final pause
   function automatic chain_type next_axis(chain_type c, logic [1:0] from, ctx_type x);
      chain_type  n;
      logic       found;
      logic [1:0] s;
      n     = c;
      found = 1'b0;
      s     = SLOT_Z;
      for (int i = 0; i < 3; i++) begin
         if (!found && 2'(i) >= from && (x.present & slot_mask(2'(i), x.ybx)) != AXIS_NONE) begin
            found = 1'b1;
            s     = 2'(i);
         end
      end
      if (found) begin
         n.slot   = s;
         n.active = slot_mask(s, x.ybx);
         n.sp     = x.sp_approach;
         n.phase  = PH_A_SETUP;
      end else begin
         n.slot  = SLOT_Z;
         n.phase = PH_FINAL;
      end
      return n;
   endfunction

   function automatic chain_type advance(chain_type c, ctx_type x);
      chain_type n;
      n = c;
      unique case (c.phase)
         PH_A_SETUP: n = do_check(c, x.lb_approach, PH_A_PULSE);
         PH_L_SETUP: n = do_check(c, x.lb_leave, PH_L_PULSE);
         PH_A_PULSE: begin
            if (x.reduce_ok) n.sp = x.sp_reduced;
            n.phase = PH_A_GAP;
         end
         PH_L_PULSE: n.phase = PH_L_GAP;
         PH_A_GAP: begin
            if (c.active == AXIS_NONE) n.phase = PH_A_SETTLE;
            else n = do_check(c, x.lb_approach, PH_A_PULSE);
         end
         PH_L_GAP: begin
            if (c.active != AXIS_NONE) begin
               n = do_check(c, x.lb_leave, PH_L_PULSE);
            end else begin
               n.extra = x.leave_pulses;
               n.phase = (x.leave_pulses == '0) ? PH_L_SETTLE : PH_L_XHIGH;
            end
         end
         PH_L_XHIGH: n.phase = PH_L_XLOW;
         PH_L_XLOW: begin
            if (c.extra != '0) n.extra = c.extra - LEAVE_W'(1);
            n.phase = (n.extra == '0) ? PH_L_SETTLE : PH_L_XHIGH;
         end
         PH_A_SETTLE: begin
            n.active = slot_mask(c.slot, x.ybx);
            n.sp     = x.sp_leave;
            n.phase  = PH_L_SETUP;
         end
         PH_L_SETTLE: n = next_axis(c, (c.slot == SLOT_NONE) ? SLOT_NONE : c.slot + 2'd1, x);
         PH_FINAL: begin
            n.phase  = PH_IDLE;
            n.active = AXIS_NONE;
            n.done   = 1'b1;
         end
         default: n.phase = PH_IDLE;
      endcase
      return n;
   endfunction

   // wait loaded on entry to a phase is zero
   function automatic logic wait_zero(chain_type c, ctx_type x);
      logic z;
      case (c.phase) inside
         PH_A_SETUP, PH_L_SETUP:              z = x.pw_zero;
         PH_A_GAP, PH_L_GAP:                  z = (c.sp == '0);
         PH_A_SETTLE, PH_L_SETTLE, PH_FINAL:  z = x.settle_zero;
         PH_L_XLOW:                           z = x.base_zero;
         default:                             z = 1'b0;
      endcase
      return z;
   endfunction

   function automatic logic [TIMER_W-1:0] wait_load(chain_type c, ctx_type x);
      logic [TIMER_W-1:0] t;
      case (c.phase) inside
         PH_A_SETUP, PH_L_SETUP:              t = TIMER_W'(x.pw);
         PH_A_PULSE, PH_L_PULSE, PH_L_XHIGH:  t = TIMER_W'(x.high_time);
         PH_A_GAP, PH_L_GAP:                  t = TIMER_W'(c.sp);
         PH_A_SETTLE, PH_L_SETTLE, PH_FINAL:  t = TIMER_W'(x.settle);
         PH_L_XLOW:                           t = TIMER_W'(x.sp_xlow);
         default:                             t = '0;
      endcase
      return t;
   endfunction

   // step period shrink: p*98/100 = p - ceil(p/50)
   assign red_prod   = sp_ff * RECIP50;
   assign red_quot   = red_prod[2*DELAY_WIDTH:RED_SHIFT];
   assign red_quot50 = DELAY_WIDTH'({red_quot, 5'b0}) + DELAY_WIDTH'({red_quot, 4'b0})
                     + DELAY_WIDTH'({red_quot, 1'b0});
   assign red_rem_nz = (sp_ff != red_quot50);

   assign per_approach = sub_floor(PERIOD_W'({base_delay_ff, 4'b0}), pulse_width_ff);
   assign per_leave    = sub_floor(PERIOD_W'({base_delay_ff, 5'b0}), pulse_width_ff);

   always_comb begin
      ctx.pw           = pulse_width_ff;
      ctx.high_time    = (pulse_width_ff == '0) ? PULSE_W'(1) : pulse_width_ff;
      ctx.settle       = settle_time_ff;
      ctx.pw_zero      = (pulse_width_ff == '0);
      ctx.settle_zero  = (settle_time_ff == '0);
      ctx.base_zero    = (base_delay_ff == '0);
      ctx.lb_approach  = req_limit_pins ^ limit_invert_ff;
      ctx.lb_leave     = ~(req_limit_pins ^ limit_invert_ff);
      ctx.present      = axes_present_ff;
      ctx.ybx          = y_before_x_ff;
      ctx.leave_pulses = leave_pulses_ff;
      ctx.sp_approach  = sat_delay(per_approach);
      ctx.sp_leave     = sat_delay(per_leave);
      ctx.sp_reduced   = sp_ff - DELAY_WIDTH'(red_quot) - DELAY_WIDTH'(red_rem_nz);
      ctx.sp_xlow      = sat_delay(PERIOD_W'({base_delay_ff, 5'b0}));
      ctx.reduce_ok    = (sp_ff > DELAY_WIDTH'(base_delay_ff));
   end

   // one tick: count down, or run the chain of phase changes whose wait is zero
   always_comb begin
      chain_type c;
      logic      run;
      c.phase  = phase_ff;
      c.slot   = slot_ff;
      c.active = active_ff;
      c.sp     = sp_ff;
      c.extra  = extra_ff;
      c.done   = 1'b0;
      run      = 1'b0;
      timer_in = timer_ff;
      if (phase_ff == PH_IDLE) begin
         if (req_start_req) begin
            c   = next_axis(c, SLOT_Z, ctx);
            run = 1'b1;
         end
      end else if (timer_ff > TIMER_W'(1)) begin
         timer_in = timer_ff - TIMER_W'(1);
      end else begin
         c   = advance(c, ctx);
         run = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
         if (run && c.phase != PH_IDLE && wait_zero(c, ctx)) c = advance(c, ctx);
      end
      if (run) timer_in = wait_load(c, ctx);
      chain_end = c;
   end

   assign phase_in  = chain_end.phase;
   assign slot_in   = chain_end.slot;
   assign active_in = chain_end.active;
   assign sp_in     = chain_end.sp;
   assign extra_in  = chain_end.extra;

   always_comb begin
      logic [AXIS_W-1:0] stp;
      logic [AXIS_W-1:0] dir;
      case (chain_end.phase) inside
         PH_A_PULSE, PH_L_PULSE: stp = chain_end.active;
         PH_L_XHIGH:             stp = slot_mask(chain_end.slot, y_before_x_ff);
         default:                stp = AXIS_NONE;
      endcase
      case (chain_end.phase) inside
         PH_A_SETUP, PH_A_PULSE, PH_A_GAP, PH_A_SETTLE: dir = AXIS_ALL;
         default:                                       dir = AXIS_NONE;
      endcase
      rsp_new.step      = stp ^ output_invert_ff[2:0];
      rsp_new.dir       = dir ^ output_invert_ff[5:3];
      rsp_new.enable    = (chain_end.phase != PH_IDLE);
      rsp_new.busy      = (chain_end.phase != PH_IDLE);
      rsp_new.done      = chain_end.done;
      rsp_new.pos_clear = chain_end.done;
   end

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_take   = rsp_valid_ff & ~rsp_stall;

   // output register with a one-entry skid behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_new;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff   <= RST_PULSE_WIDTH;
         output_invert_ff <= RST_OUTPUT_INVERT;
         limit_invert_ff  <= RST_LIMIT_INVERT;
         base_delay_ff    <= RST_BASE_DELAY;
         leave_pulses_ff  <= RST_LEAVE_PULSES;
         axes_present_ff  <= RST_AXES_PRESENT;
         y_before_x_ff    <= RST_Y_BEFORE_X;
         settle_time_ff   <= RST_SETTLE_TIME;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PULSE_WIDTH:   pulse_width_ff   <= csr_wdata[PULSE_W-1:0];
            CSR_OUTPUT_INVERT: output_invert_ff <= csr_wdata[INVERT_W-1:0];
            CSR_LIMIT_INVERT:  limit_invert_ff  <= csr_wdata[AXIS_W-1:0];
            CSR_BASE_DELAY:    base_delay_ff    <= csr_wdata[BASE_W-1:0];
            CSR_LEAVE_PULSES:  leave_pulses_ff  <= csr_wdata[LEAVE_W-1:0];
            CSR_AXES_PRESENT:  axes_present_ff  <= csr_wdata[AXIS_W-1:0];
            CSR_Y_BEFORE_X:    y_before_x_ff    <= csr_wdata[0];
            CSR_SETTLE_TIME:   settle_time_ff   <= csr_wdata[SETTLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         slot_ff   <= SLOT_Z;
         active_ff <= AXIS_NONE;
         sp_ff     <= '0;
         timer_ff  <= '0;
         extra_ff  <= '0;
      end else if (req_accept) begin
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         active_ff <= active_in;
         sp_ff     <= sp_in;
         timer_ff  <= timer_in;
         extra_ff  <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_pins      = rsp_data_ff.step;
   assign rsp_dir_pins       = rsp_data_ff.dir;
   assign rsp_motor_enable   = rsp_data_ff.enable;
   assign rsp_busy_res       = rsp_data_ff.busy;
   assign rsp_done_res       = rsp_data_ff.done;
   assign rsp_position_clear = rsp_data_ff.pos_clear;

   // a running sequence never rests on an expired wait
   `CHK_IMPLIES(a_wait_loaded, clock, reset, phase_ff != PH_IDLE, timer_ff != '0, "busy with empty wait")
   `CHK_IMPLIES(a_idle_no_axes, clock, reset, phase_ff == PH_IDLE, active_ff == AXIS_NONE, "axes left active when idle")
   `CHK_IMPLIES(a_skid_order, clock, reset, skid_valid_ff, rsp_valid_ff, "skid entry without output entry")
   `CHK_IMPLIES(a_done_drops_busy, clock, reset, rsp_valid_ff && rsp_data_ff.done, !rsp_data_ff.busy && !rsp_data_ff.enable, "done while busy")
   `CHK_NEXT(a_wait_counts, clock, reset, req_accept && phase_ff != PH_IDLE && timer_ff > 1, timer_ff == $past(timer_ff) - 1, "wait did not count down")

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the limit switch homing sequencer
// ----------------------------------------------------------------------------
// Every request is one timebase tick with a start bit and raw switch levels.
// A behavioral model of the sequencer inside the bench predicts the response
// levels of each accepted request. A short scripted table covers reset
// levels, inversion, the no-axis case and the first steps of a homing run.
// Randomized bursts follow under several register settings. Switch levels
// drift like real switches with some noise, and both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top
   import cnc_home_pkg::*;
();

   localparam int DELAY_W     = 24;
   localparam int CYCLE_LIMIT = 100000;
   localparam int IDLE_PCT    = 34;
   localparam int PRINT_CAP   = 40;

   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

   typedef enum logic [3:0] {
      HS_IDLE, HS_A_SETUP, HS_A_PULSE, HS_A_GAP, HS_A_SETTLE,
      HS_L_SETUP, HS_L_PULSE, HS_L_GAP, HS_L_XHIGH, HS_L_XLOW,
      HS_L_SETTLE, HS_FINAL
   } home_phase_type;

   typedef struct {
      logic [PULSE_W-1:0]  pw;
      logic [INVERT_W-1:0] inv;
      logic [AXIS_W-1:0]   linv;
      logic [BASE_W-1:0]   base;
      logic [LEAVE_W-1:0]  leave;
      logic [AXIS_W-1:0]   axes;
      logic                yfirst;
      logic [SETTLE_W-1:0] settle;
   } home_cfg_type;

   typedef enum {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      csr_index_type         reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      logic                  start;
      logic [AXIS_W-1:0]     pins;
      bit                    known;
      rsp_payload_type       want;
   } script_row_type;

   // step, dir, enable, busy, done, position clear
   localparam rsp_payload_type LEVELS_IDLE         = '0;
   localparam rsp_payload_type LEVELS_INVERTED     = {AXIS_ALL, AXIS_ALL, 4'b0000};
   localparam rsp_payload_type LEVELS_DONE         = {AXIS_NONE, AXIS_NONE, 4'b0011};
   localparam rsp_payload_type LEVELS_WAITING      = {AXIS_NONE, AXIS_NONE, 4'b1100};
   localparam rsp_payload_type LEVELS_Z_STEP       = {AXIS_Z, AXIS_ALL, 4'b1100};
   localparam rsp_payload_type LEVELS_APPROACH_GAP = {AXIS_NONE, AXIS_ALL, 4'b1100};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_start_req;
   logic [AXIS_W-1:0]      req_limit_pins;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [AXIS_W-1:0]      rsp_step_pins;
   logic [AXIS_W-1:0]      rsp_dir_pins;
   logic                   rsp_motor_enable;
   logic                   rsp_busy_res;
   logic                   rsp_done_res;
   logic                   rsp_position_clear;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bit calm = 1'b0;
   int cycles = 0;
   int mismatches = 0;
   int requests = 0;
   int responses = 0;
   int done_pulses = 0;
   int writes_done = 0;

   rsp_payload_type expected_levels_q[$];

   // homing model state
   home_cfg_type         cfg;
   home_phase_type       hs_phase;
   logic [1:0]           hs_slot;
   logic [AXIS_W-1:0]    hs_moving;
   logic [DELAY_W-1:0]   hs_period;
   logic [DELAY_W-1:0]   hs_timer;
   logic [LEAVE_W-1:0]   hs_extra;
   bit                   hs_done;

   cnc_homing_sequencer_core #(.DELAY_WIDTH(DELAY_W)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_req      (req_start_req),
      .req_limit_pins     (req_limit_pins),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_step_pins      (rsp_step_pins),
      .rsp_dir_pins       (rsp_dir_pins),
      .rsp_motor_enable   (rsp_motor_enable),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_position_clear (rsp_position_clear),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // ---------------------------------------------------------------- model

   function automatic logic [AXIS_W-1:0] axis_of_slot(input logic [1:0] s);
      logic [AXIS_W-1:0] m;
      m = AXIS_NONE;
      if (s == SLOT_Z) m = AXIS_Z;
      else if (s == SLOT_A) m = cfg.yfirst ? AXIS_Y : AXIS_X;
      else if (s == SLOT_B) m = cfg.yfirst ? AXIS_X : AXIS_Y;
      return m;
   endfunction

   function automatic logic [DELAY_W-1:0] clamp_delay(input logic [63:0] v);
      return (v > 64'(DELAY_MAX)) ? DELAY_MAX : v[DELAY_W-1:0];
   endfunction

   // a zero pulse width still gives one high tick
   function automatic logic [DELAY_W-1:0] high_ticks();
      return (cfg.pw == '0) ? DELAY_W'(1) : DELAY_W'(cfg.pw);
   endfunction

   function automatic void enter_phase(input home_phase_type ph, input logic [DELAY_W-1:0] t);
      hs_phase = ph;
      hs_timer = t;
   endfunction

   function automatic void begin_axis(input logic [1:0] s, input bit leaving);
      logic [63:0] span;
      span = leaving ? (64'(cfg.base) << 5) : (64'(cfg.base) << 4);
      hs_slot = s;
      hs_moving = axis_of_slot(s);
      hs_period = (span > 64'(cfg.pw)) ? clamp_delay(span - 64'(cfg.pw)) : '0;
      if (leaving) enter_phase(HS_L_SETUP, DELAY_W'(cfg.pw));
      else enter_phase(HS_A_SETUP, DELAY_W'(cfg.pw));
   endfunction

   function automatic void seek_axis(input int from);
      int s;
      for (s = from; s < 3; s++) begin
         if ((cfg.axes & axis_of_slot(2'(s))) != AXIS_NONE) begin
            begin_axis(2'(s), 1'b0);
            return;
         end
      end
      hs_slot = SLOT_Z;
      enter_phase(HS_FINAL, DELAY_W'(cfg.settle));
   endfunction

   // axes whose switch reads low (approach) or released (leave) stop moving
   function automatic void sample_switches(input bit leaving, input logic [AXIS_W-1:0] pins);
      logic [AXIS_W-1:0] level;
      level = pins ^ cfg.linv;
      if (leaving) level = ~level;
      hs_moving &= level;
      if (leaving) enter_phase(HS_L_PULSE, high_ticks());
      else enter_phase(HS_A_PULSE, high_ticks());
   endfunction

   function automatic void advance_phase(input logic [AXIS_W-1:0] pins);
      case (hs_phase)
         HS_A_SETUP: sample_switches(1'b0, pins);
         HS_L_SETUP: sample_switches(1'b1, pins);
         HS_A_PULSE: begin
            if (hs_period > DELAY_W'(cfg.base))
               hs_period = DELAY_W'((64'(hs_period) * 64'd98) / 64'd100);
            enter_phase(HS_A_GAP, hs_period);
         end
         HS_L_PULSE: enter_phase(HS_L_GAP, hs_period);
         HS_A_GAP: begin
            if (hs_moving == AXIS_NONE) enter_phase(HS_A_SETTLE, DELAY_W'(cfg.settle));
            else sample_switches(1'b0, pins);
         end
         HS_L_GAP: begin
            if (hs_moving != AXIS_NONE) begin
               sample_switches(1'b1, pins);
            end else begin
               hs_extra = cfg.leave;
               if (hs_extra == '0) enter_phase(HS_L_SETTLE, DELAY_W'(cfg.settle));
               else enter_phase(HS_L_XHIGH, high_ticks());
            end
         end
         HS_L_XHIGH: enter_phase(HS_L_XLOW, clamp_delay(64'(cfg.base) << 5));
         HS_L_XLOW: begin
            if (hs_extra != '0) hs_extra--;
            if (hs_extra == '0) enter_phase(HS_L_SETTLE, DELAY_W'(cfg.settle));
            else enter_phase(HS_L_XHIGH, high_ticks());
         end
         HS_A_SETTLE: begin_axis(hs_slot, 1'b1);
         HS_L_SETTLE: seek_axis(int'(hs_slot) + 1);
         HS_FINAL: begin
            enter_phase(HS_IDLE, '0);
            hs_moving = AXIS_NONE;
            hs_done = 1'b1;
         end
         default: enter_phase(HS_IDLE, '0);
      endcase
   endfunction

   function automatic rsp_payload_type homing_tick(input logic start,
                                                   input logic [AXIS_W-1:0] pins);
      rsp_payload_type r;
      logic [AXIS_W-1:0] stp;
      logic [AXIS_W-1:0] dir;
      hs_done = 1'b0;
      if (hs_phase == HS_IDLE) begin
         if (start) seek_axis(0);
      end else if (hs_timer != '0) begin
         hs_timer--;
      end
      // zero-length waits resolve within the same tick
      while (hs_phase != HS_IDLE && hs_timer == '0)
         advance_phase(pins);
      stp = AXIS_NONE;
      dir = AXIS_NONE;
      if (hs_phase inside {HS_A_SETUP, HS_A_PULSE, HS_A_GAP, HS_A_SETTLE}) dir = AXIS_ALL;
      if (hs_phase == HS_A_PULSE || hs_phase == HS_L_PULSE) stp = hs_moving;
      if (hs_phase == HS_L_XHIGH) stp = axis_of_slot(hs_slot);
      r.step = stp ^ cfg.inv[2:0];
      r.dir = dir ^ cfg.inv[5:3];
      r.enable = (hs_phase != HS_IDLE);
      r.busy = (hs_phase != HS_IDLE);
      r.done = hs_done;
      r.pos_clear = hs_done;
      return r;
   endfunction

   function automatic void latch_register(input csr_index_type idx,
                                          input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_PULSE_WIDTH:   cfg.pw = d[PULSE_W-1:0];
         CSR_OUTPUT_INVERT: cfg.inv = d[INVERT_W-1:0];
         CSR_LIMIT_INVERT:  cfg.linv = d[AXIS_W-1:0];
         CSR_BASE_DELAY:    cfg.base = d[BASE_W-1:0];
         CSR_LEAVE_PULSES:  cfg.leave = d[LEAVE_W-1:0];
         CSR_AXES_PRESENT:  cfg.axes = d[AXIS_W-1:0];
         CSR_Y_BEFORE_X:    cfg.yfirst = d[0];
         CSR_SETTLE_TIME:   cfg.settle = d[SETTLE_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("response %0d: %s", responses, msg);
   endtask

   task automatic compare_levels(input rsp_payload_type got, input rsp_payload_type want);
      if (got.step != want.step)
         report_mismatch($sformatf("step_pins %0h, expected %0h", got.step, want.step));
      if (got.dir != want.dir)
         report_mismatch($sformatf("dir_pins %0h, expected %0h", got.dir, want.dir));
      if (got.enable != want.enable)
         report_mismatch($sformatf("motor_enable %0b, expected %0b", got.enable, want.enable));
      if (got.busy != want.busy)
         report_mismatch($sformatf("busy_res %0b, expected %0b", got.busy, want.busy));
      if (got.done != want.done)
         report_mismatch($sformatf("done_res %0b, expected %0b", got.done, want.done));
      if (got.pos_clear != want.pos_clear)
         report_mismatch($sformatf("position_clear %0b, expected %0b",
                                   got.pos_clear, want.pos_clear));
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_payload_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_step_pins, rsp_dir_pins, rsp_motor_enable, rsp_busy_res,
                rsp_done_res, rsp_position_clear};
         responses++;
         if (got.done) done_pulses++;
         if (expected_levels_q.size() == 0) report_mismatch("response with nothing outstanding");
         else compare_levels(got, expected_levels_q.pop_front());
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, expected_levels_q.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------- stimulus

   task automatic send_tick(input logic start, input logic [AXIS_W-1:0] pins,
                            input bit known, input rsp_payload_type want);
      rsp_payload_type predicted;
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_limit_pins <= pins;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = homing_tick(start, pins);
      expected_levels_q.push_back(known ? want : predicted);
      requests++;
   endtask

   // drop valid, let every response come back, then let the pipe run idle
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_levels_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_write <= 1'b0;
      latch_register(idx, d);
      writes_done++;
   endtask

   task automatic write_settings(input home_cfg_type c);
      csr_put(CSR_PULSE_WIDTH, CSR_DATA_W'(c.pw));
      csr_put(CSR_OUTPUT_INVERT, CSR_DATA_W'(c.inv));
      csr_put(CSR_LIMIT_INVERT, CSR_DATA_W'(c.linv));
      csr_put(CSR_BASE_DELAY, CSR_DATA_W'(c.base));
      csr_put(CSR_LEAVE_PULSES, CSR_DATA_W'(c.leave));
      csr_put(CSR_AXES_PRESENT, CSR_DATA_W'(c.axes));
      csr_put(CSR_Y_BEFORE_X, CSR_DATA_W'(c.yfirst));
      csr_put(CSR_SETTLE_TIME, CSR_DATA_W'(c.settle));
   endtask

   function automatic script_row_type tick_row(input logic s, input logic [AXIS_W-1:0] p);
      script_row_type r;
      r.kind = ROW_TICK;
      r.reg_index = CSR_PULSE_WIDTH;
      r.reg_data = '0;
      r.start = s;
      r.pins = p;
      r.known = 1'b0;
      r.want = LEVELS_IDLE;
      return r;
   endfunction

   function automatic script_row_type known_row(input logic s, input logic [AXIS_W-1:0] p,
                                                input rsp_payload_type want);
      script_row_type r;
      r = tick_row(s, p);
      r.known = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic script_row_type csr_row(input csr_index_type idx,
                                              input logic [CSR_DATA_W-1:0] d);
      script_row_type r;
      r = tick_row(1'b0, AXIS_NONE);
      r.kind = ROW_CSR;
      r.reg_index = idx;
      r.reg_data = d;
      return r;
   endfunction

   initial begin : stimulus
      script_row_type    script_q[$];
      home_cfg_type      c;
      logic [AXIS_W-1:0] switch_levels;
      logic [AXIS_W-1:0] pins;
      int                burst;
      int                ph;
      int                directed;

      reset = 1'b1;
      req_valid = 1'b0;
      req_start_req = 1'b0;
      req_limit_pins = AXIS_NONE;
      csr_write = 1'b0;
      csr_index = CSR_PULSE_WIDTH;
      csr_wdata = '0;
      switch_levels = AXIS_ALL;

      cfg = '{RST_PULSE_WIDTH, RST_OUTPUT_INVERT, RST_LIMIT_INVERT, RST_BASE_DELAY,
              RST_LEAVE_PULSES, RST_AXES_PRESENT, RST_Y_BEFORE_X, RST_SETTLE_TIME};
      hs_phase = HS_IDLE;
      hs_slot = SLOT_Z;
      hs_moving = AXIS_NONE;
      hs_period = '0;
      hs_timer = '0;
      hs_extra = '0;
      hs_done = 1'b0;

      // reset levels and output inversion
      script_q.push_back(known_row(1'b0, AXIS_NONE, LEVELS_IDLE));
      script_q.push_back(known_row(1'b0, AXIS_ALL, LEVELS_IDLE));
      script_q.push_back(csr_row(CSR_OUTPUT_INVERT, 20'h3F));
      script_q.push_back(known_row(1'b0, 3'b011, LEVELS_INVERTED));
      script_q.push_back(csr_row(CSR_OUTPUT_INVERT, 20'h0));
      // no axis fitted, zero settle: start and done land on one tick
      script_q.push_back(csr_row(CSR_AXES_PRESENT, 20'(AXIS_NONE)));
      script_q.push_back(csr_row(CSR_SETTLE_TIME, 20'h0));
      script_q.push_back(known_row(1'b1, AXIS_NONE, LEVELS_DONE));
      script_q.push_back(known_row(1'b0, AXIS_NONE, LEVELS_IDLE));
      // final pause of two ticks, start while busy is dropped
      script_q.push_back(csr_row(CSR_SETTLE_TIME, 20'h2));
      script_q.push_back(known_row(1'b1, 3'b101, LEVELS_WAITING));
      script_q.push_back(known_row(1'b1, 3'b010, LEVELS_WAITING));
      script_q.push_back(known_row(1'b0, AXIS_NONE, LEVELS_DONE));
      // zero pulse width, unit base delay, Y before X
      script_q.push_back(csr_row(CSR_PULSE_WIDTH, 20'h0));
      script_q.push_back(csr_row(CSR_BASE_DELAY, 20'h1));
      script_q.push_back(csr_row(CSR_LEAVE_PULSES, 20'h0));
      script_q.push_back(csr_row(CSR_AXES_PRESENT, 20'(AXIS_ALL)));
      script_q.push_back(csr_row(CSR_LIMIT_INVERT, 20'(AXIS_NONE)));
      script_q.push_back(csr_row(CSR_Y_BEFORE_X, 20'h1));
      script_q.push_back(known_row(1'b1, AXIS_ALL, LEVELS_Z_STEP));
      script_q.push_back(known_row(1'b1, AXIS_ALL, LEVELS_APPROACH_GAP));
      script_q.push_back(tick_row(1'b0, AXIS_NONE));
      script_q.push_back(tick_row(1'b0, AXIS_Z));
      script_q.push_back(tick_row(1'b1, AXIS_X));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_q[i]) begin
         if (script_q[i].kind == ROW_CSR) begin
            settle_idle();
            csr_put(script_q[i].reg_index, script_q[i].reg_data);
         end else begin
            send_tick(script_q[i].start, script_q[i].pins, script_q[i].known, script_q[i].want);
         end
      end
      directed = requests;

      for (ph = 0; ph < 8; ph++) begin
         c.pw = PULSE_W'($urandom_range(4));
         c.inv = INVERT_W'($urandom_range(63));
         c.linv = AXIS_W'($urandom_range(7));
         c.base = BASE_W'($urandom_range(3));
         c.leave = LEAVE_W'($urandom_range(3));
         c.axes = AXIS_W'($urandom_range(7));
         c.yfirst = 1'($urandom_range(1));
         c.settle = SETTLE_W'($urandom_range(8));
         burst = 55;
         case (ph)
            0: begin
               c.pw = '0;
               c.inv = '0;
               c.linv = AXIS_NONE;
               c.base = 16'd1;
               c.leave = '0;
               c.axes = AXIS_Z;
               c.yfirst = 1'b0;
               c.settle = '0;
            end
            1: begin
               c.pw = 8'd1;
               c.inv = 6'h3F;
               c.linv = AXIS_ALL;
               c.base = 16'd1;
               c.leave = 8'd2;
               c.axes = AXIS_X | AXIS_Y;
               c.yfirst = 1'b1;
               c.settle = 20'd3;
            end
            2: begin
               c.pw = 8'd3;
               c.base = 16'd2;
               c.leave = 8'd1;
               c.axes = AXIS_X;
               c.yfirst = 1'b0;
               c.settle = 20'd1;
            end
            5: begin
               c.axes = AXIS_NONE;
               c.settle = SETTLE_W'($urandom_range(2));
               burst = 40;
            end
            // pulse width above 16 times the base: approach period floors at zero
            6: begin
               c.pw = 8'd20;
               c.base = 16'd1;
            end
            7: begin
               c.pw = 8'hFF;
               c.inv = 6'h3F;
               c.linv = AXIS_ALL;
               c.base = 16'hFFFF;
               c.leave = 8'hFF;
               c.axes = AXIS_ALL;
               c.yfirst = 1'b1;
               c.settle = 20'hFFFFF;
               burst = 40;
            end
            default: ;
         endcase

         settle_idle();
         write_settings(c);
         calm = (ph == 1);

         repeat (burst) begin
            // switches drift slowly, with an occasional noisy sample
            if ($urandom_range(5) == 0) switch_levels[$urandom_range(2)] ^= 1'b1;
            pins = ($urandom_range(15) == 0) ? AXIS_W'($urandom) : switch_levels;
            send_tick($urandom_range(99) < 30, pins, 1'b0, LEVELS_IDLE);
         end
         calm = 1'b0;
      end

      settle_idle();

      $display("ran %0d tick requests (%0d scripted) over %0d register writes",
               requests, directed, writes_done);
      $display("checked %0d responses, %0d homing completions, %0d mismatches",
               responses, done_pulses, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* cnc_homing_sequencer_core.f */
+incdir+src
src/cnc_home_pkg.sv
src/cnc_homing_sequencer_core.sv
test/tb_top.sv
